// File: src/rpgd_pkg.sv
// Shared types and constants for the revolution period / rpm block.
package rpgd_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned CntW = 5;
  localparam logic [DataW-1:0] CpmReset = 32'd960000000;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_DIVIDE,
    ST_OUTPUT
  } rpgd_state_t;

  typedef struct packed {
    logic load;
    logic update;
    logic div_step;
    logic out_load;
  } rpgd_cmd_t;

  typedef struct packed {
    logic div_last;
    logic out_free;
  } rpgd_stat_t;

endpackage

// File: src/rpgd_if.sv
// Handshake channel interfaces for edge items and result items.
interface rpgd_in_if;
  import rpgd_pkg::*;
  logic             valid;
  logic             ready;
  logic [DataW-1:0] edge_stamp;
  modport source (output valid, output edge_stamp, input ready);
  modport sink (input valid, input edge_stamp, output ready);
endinterface

interface rpgd_out_if;
  import rpgd_pkg::*;
  logic             valid;
  logic             ready;
  logic [DataW-1:0] interval;
  logic [DataW-1:0] rev_period;
  logic [DataW-1:0] rpm;
  logic             rev_done;
  modport source (output valid, output interval, output rev_period, output rpm,
                  output rev_done, input ready);
  modport sink (input valid, input interval, input rev_period, input rpm,
                input rev_done, output ready);
endinterface

// File: src/rpgd_ctrl.sv
// Sequencing state machine: accept, update, divide, hand off the result.
module rpgd_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  rpgd_pkg::rpgd_stat_t stat,
  output rpgd_pkg::rpgd_cmd_t  cmd
);
  import rpgd_pkg::*;

  rpgd_state_t state;
  rpgd_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    in_ready = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          state_next = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        cmd.update = 1'b1;
        state_next = ST_DIVIDE;
      end
      ST_DIVIDE: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) begin
          state_next = ST_OUTPUT;
        end
      end
      ST_OUTPUT: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// File: src/rpgd_dp.sv
// Datapath: edge state, gap test, saturating sum, serial divider, output register.
module rpgd_dp (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_wr_en,
  input  logic [rpgd_pkg::DataW-1:0]   cfg_wr_data,
  input  logic [rpgd_pkg::DataW-1:0]   edge_stamp,
  input  rpgd_pkg::rpgd_cmd_t          cmd,
  output rpgd_pkg::rpgd_stat_t         stat,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [rpgd_pkg::DataW-1:0]   out_interval,
  output logic [rpgd_pkg::DataW-1:0]   out_rev_period,
  output logic [rpgd_pkg::DataW-1:0]   out_rpm,
  output logic                         out_rev_done
);
  import rpgd_pkg::*;

  logic [DataW-1:0] cpm;
  logic             seen_first;
  logic [DataW-1:0] last_stamp;
  logic [DataW-1:0] prev_interval;
  logic [DataW-1:0] running_sum;
  logic [DataW-1:0] held_period;
  logic [DataW-1:0] interval;
  logic             pair;
  logic             done;
  logic [DataW-1:0] divisor;
  logic [DataW-1:0] div_quo;
  logic [DataW-1:0] div_rem;
  logic [CntW-1:0]  div_cnt;

  logic [DataW:0]   sum_wide;
  logic [DataW-1:0] sum_sat;
  logic [DataW+1:0] prev_x3;
  logic [DataW+1:0] int_x2;
  logic             gap;
  logic [DataW-1:0] held_next;
  logic [DataW:0]   rem_sh;
  logic [DataW+1:0] diff;

  // gap test 3*prev < 2*interval, exact
  assign sum_wide  = {1'b0, running_sum} + {1'b0, interval};
  assign sum_sat   = sum_wide[DataW] ? '1 : sum_wide[DataW-1:0];
  assign prev_x3   = {2'b00, prev_interval} + {1'b0, prev_interval, 1'b0};
  assign int_x2    = {1'b0, interval, 1'b0};
  assign gap       = prev_x3 < int_x2;
  assign held_next = (pair && gap) ? sum_sat : held_period;

  // restoring divider, one quotient bit per cycle
  assign rem_sh = {div_rem, div_quo[DataW-1]};
  assign diff   = {1'b0, rem_sh} - {2'b00, divisor};

  assign stat.div_last = (div_cnt == '1);
  assign stat.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cpm           <= CpmReset;
      seen_first    <= 1'b0;
      last_stamp    <= '0;
      prev_interval <= '0;
      running_sum   <= '0;
      held_period   <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        cpm <= cfg_wr_data;
      end
      if (cmd.load) begin
        last_stamp <= edge_stamp;
        seen_first <= 1'b1;
      end
      if (cmd.update && pair) begin
        prev_interval <= interval;
        held_period   <= held_next;
        running_sum   <= gap ? '0 : sum_sat;
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      interval <= seen_first ? (edge_stamp - last_stamp) : '0;
      pair     <= seen_first;
    end
    if (cmd.update) begin
      done    <= pair && gap;
      divisor <= held_next;
      div_quo <= cpm;
      div_rem <= '0;
      div_cnt <= '0;
    end else if (cmd.div_step) begin
      div_cnt <= div_cnt + 1'b1;
      if (!diff[DataW+1]) begin
        div_rem <= diff[DataW-1:0];
        div_quo <= {div_quo[DataW-2:0], 1'b1};
      end else begin
        div_rem <= rem_sh[DataW-1:0];
        div_quo <= {div_quo[DataW-2:0], 1'b0};
      end
    end
    if (cmd.out_load) begin
      out_interval   <= interval;
      out_rev_period <= divisor;
      out_rpm        <= (divisor == '0) ? '0 : div_quo;
      out_rev_done   <= done;
    end
  end

endmodule

// File: src/rev_period_gap_detect_rpm.sv
// Top level: revolution period and rpm from missing-tooth edge timestamps.
// Each edge item carries a 32-bit timestamp; the block reports the interval since the
// previous edge, the period of the last completed revolution (closed when an interval
// exceeds 1.5 times the previous one), rpm = counts_per_minute / period (0 for a zero
// period), and a flag for a closed revolution. An edge goes through these steps from
// acceptance to a ready result: the timestamp is captured at acceptance, then ST_UPDATE
// updates the revolution state, ST_DIVIDE runs the 32-bit bit-serial divider and
// ST_OUTPUT loads the output register once it is free. The input is accepted again in
// the cycle after the result loads, even while it waits to be taken, but not while an
// item is in progress; a result that is not taken holds the next item in the output
// stage. counts_per_minute resets to 960000000 and is written through cfg_wr_en.
module rev_period_gap_detect_rpm (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_wr_en,
  input  logic [rpgd_pkg::DataW-1:0] cfg_wr_data,
  rpgd_in_if.sink                    in_ch,
  rpgd_out_if.source                 out_ch
);
  import rpgd_pkg::*;

  rpgd_cmd_t  cmd;
  rpgd_stat_t stat;

  rpgd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  rpgd_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .edge_stamp     (in_ch.edge_stamp),
    .cmd            (cmd),
    .stat           (stat),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .out_interval   (out_ch.interval),
    .out_rev_period (out_ch.rev_period),
    .out_rpm        (out_ch.rpm),
    .out_rev_done   (out_ch.rev_done)
  );

`ifndef NO_ASSERTIONS
  a_accept_then_update: assert property (@(posedge clk) disable iff (rst)
    (in_ch.valid && in_ch.ready) |=> cmd.update)
    else $error("accepted item not followed by state update");

  a_busy_not_ready: assert property (@(posedge clk) disable iff (rst)
    (cmd.update || cmd.div_step) |-> !in_ch.ready)
    else $error("input ready while an item is in progress");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!out_ch.valid || out_ch.ready))
    else $error("result register overwritten before taken");

  a_taken_clears: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.ready && !cmd.out_load) |=> !out_ch.valid)
    else $error("result item repeated");
`endif

endmodule
